>>> sv/half_plane_polygon_clip_assert.svh
// Assertion macros for the half-plane polygon clipper.
`ifndef HALF_PLANE_POLYGON_CLIP_ASSERT_SVH
`define HALF_PLANE_POLYGON_CLIP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HPPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hppc_pkg.sv
// Types, constants and codes shared by the half-plane polygon clipper.
package hppc_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int DIST_WIDTH   = COORD_WIDTH + 2;
    localparam int NORM_WIDTH   = 18;
    localparam int OFFSET_WIDTH = 32;
    localparam int TOL_WIDTH    = 31;
    localparam int FRAC_BITS    = 16;
    localparam int DOT_WIDTH    = COORD_WIDTH + NORM_WIDTH;
    localparam int SUM_WIDTH    =
        ((COORD_WIDTH + 3 > OFFSET_WIDTH) ? COORD_WIDTH + 3 : OFFSET_WIDTH) + 1;
    localparam int CMP_WIDTH    =
        ((DIST_WIDTH > TOL_WIDTH + 1) ? DIST_WIDTH : TOL_WIDTH + 1) + 1;
    localparam int PROD_WIDTH   = COORD_WIDTH + 1 + DIST_WIDTH;
    localparam int CNT_WIDTH    = $clog2(DIST_WIDTH + 1);
    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;

    typedef enum logic [1:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_LINE_OFFSET,
        REG_TOLERANCE
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic                          closing;
    } t_vtx_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic                          vertex_valid;
        logic                          from_crossing;
        logic                          polygon_end;
    } t_res_out;

    typedef struct packed {
        logic signed [NORM_WIDTH-1:0]   normal_x;
        logic signed [NORM_WIDTH-1:0]   normal_y;
        logic signed [OFFSET_WIDTH-1:0] line_offset;
        logic        [TOL_WIDTH-1:0]    tolerance;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_DIST,
        S_EDGE,
        S_EMIT_START,
        S_LX_GO,
        S_LX_WAIT,
        S_LY_GO,
        S_LY_WAIT,
        S_EMIT_CROSS,
        S_NEXT,
        S_EMIT_END,
        S_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        OUT_START,
        OUT_CROSS,
        OUT_END
    } t_out_kind;

    typedef struct packed {
        logic      load_in;
        logic      mul_en;
        logic      mul_y;
        logic      dist_en;
        logic      edge_load;
        logic      edge_sel;
        logic      lerp_start;
        logic      lerp_axis;
        logic      out_load;
        t_out_kind out_kind;
        logic      out_last;
        logic      update;
    } t_dp_cmd;

    typedef struct packed {
        logic begun;
        logic closing;
        logic in1;
        logic cr1;
        logic in2;
        logic cr2;
        logic lerp_idle;
        logic out_free;
    } t_dp_sts;

endpackage

>>> sv/half_plane_polygon_clip.sv
// Each crossing runs per axis a start state, a DIST_WIDTH bit shift-add multiply,
// a COORD_WIDTH bit restoring divide and a wait state.
// The clipper takes one vertex at a time; the next is taken only after the last one's
// history update, and output stalls can hold it back.
// Reset (synchronous, active low): registers to defaults, history cleared, result empty.
module half_plane_polygon_clip (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hppc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [hppc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [hppc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    // vertex transactions in
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  hppc_pkg::t_vtx_in               i_in_data,
    // clipped vertex transactions out
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output hppc_pkg::t_res_out              o_out_data
);
    import hppc_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // zero wait states on the configuration port
    assign pready = 1'b1;

    hppc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // the sequencer walks distance, the edge in and any closing edge, any end marker, history update
    hppc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // the datapath holds the output register; a waiting result stalls the sequencer
    // only when the next result is ready to load
    hppc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`include "half_plane_polygon_clip_assert.svh"

    // a taken vertex drops ready until its work is done
    `HPPC_ASSERT_NEXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready, "ready held")
    // never overwrite a result that is still waiting
    `HPPC_ASSERT_NOW(a_load_when_free, w_cmd.out_load, w_sts.out_free, "result overwritten")
    // never restart the lerp unit mid-operation
    `HPPC_ASSERT_NOW(a_lerp_idle_start, w_cmd.lerp_start, w_sts.lerp_idle, "lerp restarted")
    // a bare end marker always closes the polygon
    `HPPC_ASSERT_NOW(a_marker_ends, o_out_valid && !o_out_data.vertex_valid,
        o_out_data.polygon_end && !o_out_data.from_crossing, "bad end marker")

endmodule

>>> sv/hppc_cfg.sv
// Configuration register file behind the APB-style port.
module hppc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hppc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [hppc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [hppc_pkg::DATA_WIDTH-1:0] prdata,
    output hppc_pkg::t_cfg                  o_cfg
);
    import hppc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx = t_reg_idx'(paddr[3:2]);
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x    <= NORM_WIDTH'(65536);
            r_cfg.normal_y    <= '0;
            r_cfg.line_offset <= '0;
            r_cfg.tolerance   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_NORMAL_X:    r_cfg.normal_x    <= pwdata[NORM_WIDTH-1:0];
                REG_NORMAL_Y:    r_cfg.normal_y    <= pwdata[NORM_WIDTH-1:0];
                REG_LINE_OFFSET: r_cfg.line_offset <= pwdata[OFFSET_WIDTH-1:0];
                REG_TOLERANCE:   r_cfg.tolerance   <= pwdata[TOL_WIDTH-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_NORMAL_X:    prdata = DATA_WIDTH'(r_cfg.normal_x);
            REG_NORMAL_Y:    prdata = DATA_WIDTH'(r_cfg.normal_y);
            REG_LINE_OFFSET: prdata = DATA_WIDTH'(r_cfg.line_offset);
            REG_TOLERANCE:   prdata = DATA_WIDTH'(r_cfg.tolerance);
        endcase
    end

endmodule

>>> sv/hppc_ctrl.sv
// Sequencer that steps the clipper datapath through one vertex.
module hppc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hppc_pkg::t_dp_sts i_sts,
    output hppc_pkg::t_dp_cmd o_cmd
);
    import hppc_pkg::*;

    t_state r_state, n_state;
    logic   r_edge, n_edge;
    logic   w_in_e, w_cr_e, w_more2, w_last_start, w_last_cross, w_none;

    assign w_in_e  = r_edge ? i_sts.in2 : i_sts.in1;
    assign w_cr_e  = r_edge ? i_sts.cr2 : i_sts.cr1;
    // closing edge will emit something after the first edge
    assign w_more2 = i_sts.closing && i_sts.begun && (i_sts.in2 || i_sts.cr2);
    assign w_last_start = r_edge ? !i_sts.cr2 : (i_sts.closing && !i_sts.cr1 && !w_more2);
    assign w_last_cross = r_edge ? 1'b1 : (i_sts.closing && !w_more2);
    assign w_none = i_sts.closing && !(i_sts.begun &&
                    (i_sts.in1 || i_sts.cr1 || i_sts.in2 || i_sts.cr2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_edge  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_edge     = r_edge;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL_X;
                end
            end
            S_MUL_X: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_y  = 1'b1;
                n_state      = S_DIST;
            end
            S_DIST: begin
                o_cmd.dist_en = 1'b1;
                n_edge        = 1'b0;
                n_state       = i_sts.begun ? S_EDGE : S_NEXT;
            end
            S_EDGE: begin
                o_cmd.edge_load = 1'b1;
                o_cmd.edge_sel  = r_edge;
                n_state         = S_EMIT_START;
            end
            S_EMIT_START: begin
                if (!w_in_e || i_sts.out_free) begin
                    o_cmd.out_load = w_in_e;
                    o_cmd.out_kind = OUT_START;
                    o_cmd.out_last = w_last_start;
                    n_state        = w_cr_e ? S_LX_GO : S_NEXT;
                end
            end
            S_LX_GO: begin
                o_cmd.lerp_start = 1'b1;
                n_state          = S_LX_WAIT;
            end
            S_LX_WAIT: begin
                if (i_sts.lerp_idle) n_state = S_LY_GO;
            end
            S_LY_GO: begin
                o_cmd.lerp_start = 1'b1;
                o_cmd.lerp_axis  = 1'b1;
                n_state          = S_LY_WAIT;
            end
            S_LY_WAIT: begin
                if (i_sts.lerp_idle) n_state = S_EMIT_CROSS;
            end
            S_EMIT_CROSS: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_CROSS;
                    o_cmd.out_last = w_last_cross;
                    n_state        = S_NEXT;
                end
            end
            S_NEXT: begin
                priority if (!r_edge && i_sts.closing && i_sts.begun) begin
                    n_edge  = 1'b1;
                    n_state = S_EDGE;
                end else if (w_none) begin
                    n_state = S_EMIT_END;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_EMIT_END: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_END;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> sv/hppc_dp.sv
// Clipper datapath: distance, edge operands, serial lerp unit, result register.
module hppc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hppc_pkg::t_cfg     i_cfg,
    input  hppc_pkg::t_vtx_in  i_in_data,
    input  hppc_pkg::t_dp_cmd  i_cmd,
    output hppc_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hppc_pkg::t_res_out o_out_data
);
    import hppc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = DIST_WIDTH;
    localparam int PW = PROD_WIDTH;
    localparam logic signed [SUM_WIDTH-1:0] DMAX =
        {{(SUM_WIDTH-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] DMIN = ~DMAX;

    // vertex, distance and polygon history
    logic signed [CW-1:0]        r_vx, r_vy, r_fx, r_fy, r_px, r_py;
    logic signed [DW-1:0]        r_d, r_fd, r_pd;
    logic                        r_close, r_have;
    logic signed [DOT_WIDTH-1:0] r_pa, r_pb, w_mul;
    logic signed [NORM_WIDTH-1:0] w_ma;
    logic signed [CW-1:0]        w_mb;
    logic signed [DOT_WIDTH:0]   w_sum;
    logic signed [SUM_WIDTH-1:0] w_full;
    logic signed [DW-1:0]        w_d;
    logic signed [CMP_WIDTH-1:0] w_tol;

    // edge operands
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0] r_da, r_db;

    // serial multiply then divide
    logic [CW:0]          r_mcand;
    logic [DW-1:0]        r_mplier;
    logic [DW:0]          r_den;
    logic                 r_neg, r_busy, r_div, r_axis;
    logic [CW-1:0]        r_base, r_quo, r_lx, r_ly;
    logic [PW-1:0]        r_prod, w_prod_nx;
    logic [DW:0]          r_rem;
    logic [CNT_WIDTH-1:0] r_cnt;
    logic signed [CW-1:0] w_a, w_b;
    logic signed [CW:0]   w_dx;
    logic signed [DW:0]   w_den;
    logic [DW+1:0]        w_t, w_diff;
    logic                 w_ge;
    logic [CW-1:0]        w_q, w_res;

    t_res_out r_out;
    logic     r_out_valid, w_out_free;

    function automatic logic f_in(input logic signed [DW-1:0] d,
                                  input logic signed [CMP_WIDTH-1:0] tol);
        logic signed [CMP_WIDTH-1:0] e;
        e = CMP_WIDTH'(d);
        return e <= tol;
    endfunction

    function automatic logic f_cross(input logic signed [DW-1:0] da,
                                     input logic signed [DW-1:0] db,
                                     input logic signed [CMP_WIDTH-1:0] tol);
        logic signed [CMP_WIDTH-1:0] ea, eb;
        ea = CMP_WIDTH'(da);
        eb = CMP_WIDTH'(db);
        return (ea > tol && eb < -tol) || (ea < -tol && eb > tol);
    endfunction

    // distance: one shared multiplier for the x and y products
    assign w_ma  = i_cmd.mul_y ? i_cfg.normal_y : i_cfg.normal_x;
    assign w_mb  = i_cmd.mul_y ? r_vy : r_vx;
    assign w_mul = w_ma * w_mb;
    assign w_sum = {r_pa[DOT_WIDTH-1], r_pa} + {r_pb[DOT_WIDTH-1], r_pb};
    assign w_full = SUM_WIDTH'($signed(w_sum[DOT_WIDTH:FRAC_BITS]))
                  + SUM_WIDTH'(i_cfg.line_offset);
    assign w_d = (w_full > DMAX) ? DMAX[DW-1:0] :
                 (w_full < DMIN) ? DMIN[DW-1:0] : w_full[DW-1:0];
    assign w_tol = CMP_WIDTH'(i_cfg.tolerance);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_vx    <= i_in_data.vertex_x;
            r_vy    <= i_in_data.vertex_y;
            r_close <= i_in_data.closing;
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_y) r_pb <= w_mul;
            else             r_pa <= w_mul;
        end
        if (i_cmd.dist_en) r_d <= w_d;
        if (i_cmd.update) begin
            if (!r_have) begin
                r_fx <= r_vx;
                r_fy <= r_vy;
                r_fd <= r_d;
            end
            r_px <= r_vx;
            r_py <= r_vy;
            r_pd <= r_d;
        end
        if (i_cmd.edge_load) begin
            if (i_cmd.edge_sel) begin
                r_ax <= r_vx; r_ay <= r_vy; r_da <= r_d;
                r_bx <= r_fx; r_by <= r_fy; r_db <= r_fd;
            end else begin
                r_ax <= r_px; r_ay <= r_py; r_da <= r_pd;
                r_bx <= r_vx; r_by <= r_vy; r_db <= r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_have <= 1'b0;
        else if (i_cmd.update) r_have <= !r_close;
    end

    // lerp operands
    assign w_a   = i_cmd.lerp_axis ? r_ay : r_ax;
    assign w_b   = i_cmd.lerp_axis ? r_by : r_bx;
    assign w_dx  = {w_b[CW-1], w_b} - {w_a[CW-1], w_a};
    assign w_den = {r_da[DW-1], r_da} - {r_db[DW-1], r_db};

    assign w_prod_nx = {r_prod[PW-2:0], 1'b0} + (r_mplier[DW-1] ? PW'(r_mcand) : '0);
    assign w_t    = {r_rem, r_quo[CW-1]};
    assign w_diff = w_t - {1'b0, r_den};
    assign w_ge   = !w_diff[DW+1];
    assign w_q    = {r_quo[CW-2:0], w_ge};
    assign w_res  = r_neg ? (r_base - w_q) : (r_base + w_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.lerp_start) begin
            r_mcand  <= w_dx[CW] ? -w_dx : w_dx;
            r_mplier <= r_da[DW-1] ? -r_da : r_da;
            r_den    <= w_den[DW] ? -w_den : w_den;
            r_neg    <= w_dx[CW];
            r_base   <= w_a;
            r_axis   <= i_cmd.lerp_axis;
            r_prod   <= '0;
            r_cnt    <= CNT_WIDTH'(DW - 1);
        end else if (r_busy && !r_div) begin
            r_prod   <= w_prod_nx;
            r_mplier <= r_mplier << 1;
            if (r_cnt == '0) begin
                // quotient is below 2^CW, so the top bits seed the remainder
                r_rem <= w_prod_nx[PW-1:CW];
                r_quo <= w_prod_nx[CW-1:0];
                r_cnt <= CNT_WIDTH'(CW - 1);
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW:0] : w_t[DW:0];
            r_quo <= w_q;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                if (r_axis) r_ly <= w_res;
                else        r_lx <= w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
        end else if (i_cmd.lerp_start) begin
            r_busy <= 1'b1;
            r_div  <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            if (r_div) r_busy <= 1'b0;
            r_div <= !r_div;
        end
    end

    // result register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)             r_out_valid <= 1'b0;
        else if (i_cmd.out_load)  r_out_valid <= 1'b1;
        else if (i_out_ready)     r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_kind)
                OUT_START: r_out <= '{r_ax, r_ay, 1'b1, 1'b0, i_cmd.out_last};
                OUT_CROSS: r_out <= '{r_lx, r_ly, 1'b1, 1'b1, i_cmd.out_last};
                default:   r_out <= '{'0, '0, 1'b0, 1'b0, 1'b1};
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.begun     = r_have;
    assign o_sts.closing   = r_close;
    assign o_sts.in1       = f_in(r_pd, w_tol);
    assign o_sts.cr1       = f_cross(r_pd, r_d, w_tol);
    assign o_sts.in2       = f_in(r_d, w_tol);
    assign o_sts.cr2       = f_cross(r_d, r_fd, w_tol);
    assign o_sts.lerp_idle = !r_busy;
    assign o_sts.out_free  = w_out_free;

endmodule
